// ===== rtl/core/ppd_pkg.sv =====
// Shared types and constants for the particle push and charge deposit core.
`default_nettype none
package ppd_pkg;

    localparam int MAX_CELLS = 1024;
    localparam int GRID_AW   = $clog2(MAX_CELLS + 1);
    localparam int MOD_BITS  = 18;

    typedef enum logic [1:0] {
        OP_LOAD_FIELD = 2'd0,
        OP_PUSH       = 2'd1,
        OP_READ_CHG   = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_VEL_SCALE = 2'd0,
        CFG_POS_SCALE = 2'd1,
        CFG_CHARGE    = 2'd2,
        CFG_CELLS     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [10:0]        cell_index;
        logic signed [31:0] field_value;
        logic [9:0]         particle_cell;
        logic signed [15:0] particle_offset;
        logic signed [31:0] particle_velocity;
        logic               last_particle;
    } in_item_t;

    typedef struct packed {
        logic [9:0]         new_cell;
        logic signed [15:0] new_offset;
        logic signed [31:0] new_velocity;
        logic signed [31:0] charge_value;
        logic signed [63:0] energy_sum;
        logic               energy_valid;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_RD, ST_F0, ST_F1, ST_V0, ST_V1, ST_X0, ST_X1,
        ST_ACC, ST_MOD, ST_WRAP, ST_D0, ST_D1, ST_D2, ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/ppd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ppd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1025,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/pic_particle_push_deposit_core.sv =====
// Operations: field load, charge read and particle push. A push runs the 18-step wrap
// (modulo) loop and the read-modify-write of two charge cells on the charge RAM. One
// transaction at a time; the next is taken once the result has been issued.
// Reset: asynchronous, active low; then a pass over all 1025 cells zeroes the charge RAM
// while input is stalled (config writes still taken). Field RAM is not cleared.
`default_nettype none
module pic_particle_push_deposit_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire ppd_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output ppd_pkg::out_item_t      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    localparam int AW    = ppd_pkg::GRID_AW;
    localparam int MOD_W = ppd_pkg::MOD_BITS;

    // configuration
    logic signed [31:0] vscale_reg, pscale_reg, charge_reg;
    logic [10:0]        cells_reg;

    ppd_pkg::state_t state_reg, state_next;

    // captured transaction
    logic [1:0]         op_reg;
    logic [10:0]        addr_reg;
    logic [9:0]         c_reg;
    logic signed [15:0] x_reg;
    logic signed [31:0] v_reg;
    logic               last_reg;

    // datapath registers
    logic signed [49:0] acc0_reg;
    logic signed [31:0] e_reg, vn_reg, chg_reg, part_reg;
    logic signed [63:0] prod_reg, energy_reg;
    logic signed [17:0] di_reg;
    logic signed [15:0] xn_reg;
    logic [MOD_W-1:0]   mag_reg;
    logic               neg_reg;
    logic [10:0]        rem_reg;
    logic [4:0]         cnt_reg;
    logic [9:0]         m_reg;
    logic [10:0]        clr_reg;

    logic               out_valid_reg;
    ppd_pkg::out_item_t out_reg, out_next;

    // RAM ports
    logic          f_we, c_we;
    logic [AW-1:0] f_waddr, f_raddr, c_waddr, c_raddr;
    logic [31:0]   f_wdata, c_wdata, f_rdata, c_rdata;

    ppd_ram #(.WIDTH(32), .DEPTH(ppd_pkg::MAX_CELLS + 1)) u_field_ram (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    ppd_ram #(.WIDTH(32), .DEPTH(ppd_pkg::MAX_CELLS + 1)) u_charge_ram (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    logic accept, out_take, addr_ok_in;
    logic [9:0] c_clamp;

    assign accept     = in_valid && !in_stall;
    assign out_take   = out_valid_reg && !out_stall;
    assign addr_ok_in = (in_data.cell_index <= 11'(ppd_pkg::MAX_CELLS));
    assign c_clamp    = ({1'b0, in_data.particle_cell} >= cells_reg)
                        ? 10'(cells_reg - 11'd1) : in_data.particle_cell;

    assign in_stall  = (state_reg != ppd_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    // arithmetic
    logic signed [17:0] w0, w1, w0n, w1n, wsel;
    logic signed [49:0] fprod, sum50, qprod;
    logic signed [63:0] mul_a;
    logic signed [31:0] mul_x, mul_y;
    logic signed [40:0] vsum;
    logic signed [31:0] vsat;
    logic signed [63:0] t_round;
    logic signed [33:0] x1r;
    logic signed [18:0] s_pos;
    logic [11:0]        trial;
    logic [10:0]        rem_step;
    logic signed [64:0] esum;
    logic signed [63:0] esat;
    logic signed [34:0] csum;
    logic signed [31:0] csat;
    logic [9:0]         m_wrap;

    always_comb
    begin
        w0    = 18'sh08000 - {{2{x_reg[15]}}, x_reg};
        w1    = 18'sh08000 + {{2{x_reg[15]}}, x_reg};
        w0n   = 18'sh08000 - {{2{xn_reg[15]}}, xn_reg};
        w1n   = 18'sh08000 + {{2{xn_reg[15]}}, xn_reg};
        fprod = $signed(f_rdata) * ((state_reg == ppd_pkg::ST_F0) ? w0 : w1);
        sum50 = acc0_reg + fprod + 50'sd32768;

        // shared 32x32 multiplier
        case (state_reg)
            ppd_pkg::ST_V0: begin mul_x = vscale_reg; mul_y = e_reg;  end
            ppd_pkg::ST_X0: begin mul_x = pscale_reg; mul_y = vn_reg; end
            default:        begin mul_x = v_reg;      mul_y = vn_reg; end
        endcase
        mul_a = mul_x * mul_y;

        t_round = prod_reg + 64'sd8388608;
        vsum    = {{9{v_reg[31]}}, v_reg} + {t_round[63], t_round[63:24]};
        if (vsum > 41'sd2147483647)
            vsat = 32'sh7fffffff;
        else if (vsum < -41'sd2147483648)
            vsat = 32'sh80000000;
        else
            vsat = vsum[31:0];

        t_round = prod_reg + 64'sh80000000;
        x1r = {{18{x_reg[15]}}, x_reg} + {{2{t_round[63]}}, t_round[63:32]}
              + 34'sd32768;

        s_pos = $signed({9'd0, c_reg}) + {di_reg[17], di_reg};

        trial    = {rem_reg, mag_reg[MOD_W-1]};
        rem_step = (trial >= {1'b0, cells_reg}) ? 11'(trial - {1'b0, cells_reg})
                                                : trial[10:0];
        m_wrap   = (neg_reg && rem_reg != 11'd0) ? 10'(cells_reg - rem_reg)
                                                 : rem_reg[9:0];

        esum = {energy_reg[63], energy_reg} + {prod_reg[63], prod_reg};
        if (esum[64] != esum[63])
            esat = esum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            esat = esum[63:0];

        wsel  = (state_reg == ppd_pkg::ST_D0) ? w0n : w1n;
        qprod = charge_reg * wsel + 50'sd32768;
        csum  = {{3{c_rdata[31]}}, c_rdata} + {{3{part_reg[31]}}, part_reg};
        if (csum > 35'sd2147483647)
            csat = 32'sh7fffffff;
        else if (csum < -35'sd2147483648)
            csat = 32'sh80000000;
        else
            csat = csum[31:0];
    end

    // result word for the transaction in hand
    always_comb
    begin
        out_next              = '0;
        out_next.charge_value = chg_reg;
        if (op_reg == ppd_pkg::OP_PUSH)
        begin
            out_next.new_cell     = m_reg;
            out_next.new_offset   = xn_reg;
            out_next.new_velocity = vn_reg;
            if (last_reg)
            begin
                out_next.energy_sum   = energy_reg;
                out_next.energy_valid = 1'b1;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppd_pkg::ST_CLEAR:
                if (clr_reg == 11'(ppd_pkg::MAX_CELLS)) state_next = ppd_pkg::ST_IDLE;
            ppd_pkg::ST_IDLE:
                if (accept)
                begin
                    if (in_data.operation == ppd_pkg::OP_PUSH)
                        state_next = ppd_pkg::ST_F0;
                    else if (in_data.operation == ppd_pkg::OP_READ_CHG && addr_ok_in)
                        state_next = ppd_pkg::ST_RD;
                    else
                        state_next = ppd_pkg::ST_DONE;
                end
            ppd_pkg::ST_RD:   state_next = ppd_pkg::ST_DONE;
            ppd_pkg::ST_F0:   state_next = ppd_pkg::ST_F1;
            ppd_pkg::ST_F1:   state_next = ppd_pkg::ST_V0;
            ppd_pkg::ST_V0:   state_next = ppd_pkg::ST_V1;
            ppd_pkg::ST_V1:   state_next = ppd_pkg::ST_X0;
            ppd_pkg::ST_X0:   state_next = ppd_pkg::ST_X1;
            ppd_pkg::ST_X1:   state_next = ppd_pkg::ST_ACC;
            ppd_pkg::ST_ACC:  state_next = ppd_pkg::ST_MOD;
            ppd_pkg::ST_MOD:
                if (cnt_reg == 5'(MOD_W - 1)) state_next = ppd_pkg::ST_WRAP;
            ppd_pkg::ST_WRAP: state_next = ppd_pkg::ST_D0;
            ppd_pkg::ST_D0:   state_next = ppd_pkg::ST_D1;
            ppd_pkg::ST_D1:   state_next = ppd_pkg::ST_D2;
            ppd_pkg::ST_D2:   state_next = ppd_pkg::ST_DONE;
            ppd_pkg::ST_DONE:
                if (!out_valid_reg || !out_stall) state_next = ppd_pkg::ST_IDLE;
            default:          state_next = ppd_pkg::ST_IDLE;
        endcase
    end

    // RAM control
    always_comb
    begin
        f_we    = 1'b0;
        f_waddr = in_data.cell_index;
        f_wdata = in_data.field_value;
        f_raddr = AW'(c_clamp);
        c_we    = 1'b0;
        c_waddr = AW'(m_reg);
        c_wdata = csat;
        c_raddr = in_data.cell_index;
        unique case (state_reg)
            ppd_pkg::ST_CLEAR:
            begin
                c_we    = 1'b1;
                c_waddr = clr_reg;
                c_wdata = 32'd0;
            end
            ppd_pkg::ST_IDLE:
                f_we = accept && in_data.operation == ppd_pkg::OP_LOAD_FIELD && addr_ok_in;
            ppd_pkg::ST_F0:
                f_raddr = AW'({1'b0, c_reg} + 11'd1);
            ppd_pkg::ST_RD:
            begin
                c_we    = 1'b1;
                c_waddr = addr_reg;
                c_wdata = 32'd0;
            end
            ppd_pkg::ST_D0:
                c_raddr = AW'(m_reg);
            ppd_pkg::ST_D1:
            begin
                c_we    = 1'b1;
                c_raddr = AW'({1'b0, m_reg} + 11'd1);
            end
            ppd_pkg::ST_D2:
            begin
                c_we    = 1'b1;
                c_waddr = AW'({1'b0, m_reg} + 11'd1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppd_pkg::ST_CLEAR;
            clr_reg       <= 11'd0;
            out_valid_reg <= 1'b0;
            energy_reg    <= 64'sd0;
            vscale_reg    <= 32'sd16777216;
            pscale_reg    <= 32'sd1677722;
            charge_reg    <= 32'sd16777216;
            cells_reg     <= 11'd1024;
            cnt_reg       <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    ppd_pkg::CFG_VEL_SCALE: vscale_reg <= cfg_data;
                    ppd_pkg::CFG_POS_SCALE: pscale_reg <= cfg_data;
                    ppd_pkg::CFG_CHARGE:    charge_reg <= cfg_data;
                    ppd_pkg::CFG_CELLS:
                        if (cfg_data[10:0] < 11'd2)
                            cells_reg <= 11'd2;
                        else if (cfg_data[10:0] > 11'(ppd_pkg::MAX_CELLS))
                            cells_reg <= 11'(ppd_pkg::MAX_CELLS);
                        else
                            cells_reg <= cfg_data[10:0];
                    default: ;
                endcase
            end

            // in DONE a taken result is replaced by the next one below
            if (out_take && state_reg != ppd_pkg::ST_DONE)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ppd_pkg::ST_CLEAR: clr_reg <= clr_reg + 11'd1;
                ppd_pkg::ST_IDLE:
                    if (accept)
                    begin
                        op_reg   <= in_data.operation;
                        addr_reg <= in_data.cell_index;
                        c_reg    <= c_clamp;
                        x_reg    <= in_data.particle_offset;
                        v_reg    <= in_data.particle_velocity;
                        last_reg <= in_data.last_particle;
                        chg_reg  <= 32'sd0;
                    end
                ppd_pkg::ST_RD:  chg_reg  <= c_rdata;
                ppd_pkg::ST_F0:  acc0_reg <= fprod;
                ppd_pkg::ST_F1:  e_reg    <= sum50[47:16];
                ppd_pkg::ST_V0:  prod_reg <= mul_a;
                ppd_pkg::ST_V1:  vn_reg   <= vsat;
                ppd_pkg::ST_X0:  prod_reg <= mul_a;
                ppd_pkg::ST_X1:
                begin
                    di_reg   <= x1r[33:16];
                    xn_reg   <= {~x1r[15], x1r[14:0]};
                    prod_reg <= mul_a;
                end
                ppd_pkg::ST_ACC:
                begin
                    energy_reg <= esat;
                    neg_reg    <= s_pos[18];
                    mag_reg    <= s_pos[18] ? MOD_W'(-s_pos) : MOD_W'(s_pos);
                    rem_reg    <= 11'd0;
                    cnt_reg    <= 5'd0;
                end
                ppd_pkg::ST_MOD:
                begin
                    rem_reg <= rem_step;
                    mag_reg <= {mag_reg[MOD_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 5'd1;
                end
                ppd_pkg::ST_WRAP: m_reg <= m_wrap;
                ppd_pkg::ST_D0, ppd_pkg::ST_D1: part_reg <= qprod[47:16];
                ppd_pkg::ST_DONE:
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg       <= out_next;
                        if (op_reg == ppd_pkg::OP_PUSH && last_reg)
                            energy_reg <= 64'sd0;
                    end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
